FILE: hdl/esd_pkg.sv
package esd_pkg;

    // Field widths of the event word and of the decoded event.
    localparam int WORD_W         = 32;
    localparam int TYPE_W         = 4;
    localparam int HIGH_TIME_BITS = 28;
    localparam int LOW_TIME_BITS  = 6;
    localparam int COORD_BITS     = 11;
    localparam int WRAP_BITS      = 30;
    localparam int TIME_W         = 64;
    localparam int CHAN_W         = 5;
    localparam int THR_W          = 8;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = THR_W;

    // Output word: x, y, polarity, channel, level, time, padded to whole bytes.
    localparam int OUT_BITS   = 2 * COORD_BITS + 1 + CHAN_W + 1 + TIME_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

    // Event word type codes.
    localparam logic [TYPE_W-1:0] TYPE_CD_OFF      = 4'h0;
    localparam logic [TYPE_W-1:0] TYPE_CD_ON       = 4'h1;
    localparam logic [TYPE_W-1:0] TYPE_TIME_HIGH   = 4'h8;
    localparam logic [TYPE_W-1:0] TYPE_EXT_TRIGGER = 4'hA;

    // Decoded event kinds.
    localparam logic KIND_CD      = 1'b0;
    localparam logic KIND_TRIGGER = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_THRESHOLD = 1'b1;

    localparam logic [THR_W-1:0] THR_RESET = 8'd10;

    // Largest value of the time-high field.
    localparam logic [HIGH_TIME_BITS-1:0] HIGH_MAX = {HIGH_TIME_BITS{1'b1}};

    // Time base as kept by the tracker. The full base is {wrap, high, six zeros}.
    typedef struct packed {
        logic                      seen;
        logic [WRAP_BITS-1:0]      wrap;
        logic [HIGH_TIME_BITS-1:0] high;
    } t_base;

    typedef struct packed {
        logic                  kind;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  pol;
        logic [CHAN_W-1:0]     chan;
        logic                  level;
        logic [TIME_W-1:0]     ts;
    } t_event;

endpackage

FILE: hdl/esd_timebase.sv
module esd_timebase
    import esd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_update,
    input  logic [HIGH_TIME_BITS-1:0] i_high,
    input  logic [THR_W-1:0]          i_threshold,
    output t_base                     o_base
);

    logic                      r_seen;
    logic [WRAP_BITS-1:0]      r_wrap;
    logic [HIGH_TIME_BITS-1:0] r_high;
    logic [HIGH_TIME_BITS-1:0] diff;
    logic [HIGH_TIME_BITS-1:0] limit;
    logic                      wrapped;

    // Both bases share the same wrap count, so the backwards step of the full
    // base is the step of the high field scaled by 64. The wrap test reduces
    // to old - new >= HIGH_MAX - threshold on the 28-bit field.
    assign diff    = r_high - i_high;
    assign limit   = HIGH_MAX - {{(HIGH_TIME_BITS - THR_W){1'b0}}, i_threshold};
    assign wrapped = r_seen && (r_high > i_high) && (diff >= limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_wrap <= '0;
            r_high <= '0;
        end else if (i_update) begin
            r_seen <= 1'b1;
            r_high <= i_high;
            if (wrapped) begin
                r_wrap <= r_wrap + {{(WRAP_BITS - 1){1'b0}}, 1'b1};
            end
        end
    end

    assign o_base = '{seen: r_seen, wrap: r_wrap, high: r_high};

endmodule

FILE: hdl/esd_decode.sv
module esd_decode
    import esd_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    input  t_base             i_base,
    input  logic              i_trigger_enable,
    output logic              o_emit,
    output logic              o_high_word,
    output t_event            o_event
);

    logic [TYPE_W-1:0]        word_type;
    logic [LOW_TIME_BITS-1:0] low_time;

    assign word_type = i_word[WORD_W-1 -: TYPE_W];
    assign low_time  = i_word[WORD_W-TYPE_W-1 -: LOW_TIME_BITS];

    always_comb begin
        o_emit      = 1'b0;
        o_high_word = 1'b0;
        o_event     = '0;
        // The base always has its six low bits clear, so adding the low time
        // is a plain concatenation.
        o_event.ts  = {i_base.wrap, i_base.high, low_time};
        case (word_type)
            TYPE_CD_OFF, TYPE_CD_ON: begin
                o_emit        = i_base.seen;
                o_event.kind  = KIND_CD;
                o_event.x     = i_word[2*COORD_BITS-1 -: COORD_BITS];
                o_event.y     = i_word[COORD_BITS-1:0];
                o_event.pol   = word_type[0];
            end
            TYPE_TIME_HIGH: begin
                o_high_word = 1'b1;
            end
            TYPE_EXT_TRIGGER: begin
                o_emit        = i_base.seen && i_trigger_enable;
                o_event.kind  = KIND_TRIGGER;
                o_event.chan  = i_word[8 +: CHAN_W];
                o_event.level = i_word[0];
            end
            default: begin
                o_emit = 1'b0;
            end
        endcase
    end

endmodule

FILE: hdl/event_stream_timestamp_decoder_core.sv
// Event stream timestamp decoder. Each 32-bit input word is decoded by its
// type in bits 31..28: time-high words update the internal microsecond time
// base, contrast-change words and (when trigger_enable is set) external
// trigger words each produce one output word stamped with the base plus the
// word's 6-bit low time, and all other words are dropped. Every word is
// dropped until the first time-high word has been seen. A time-high word that
// steps the base backwards by nearly the full 2^34 us range is taken as a
// wrap of the sensor clock and bumps a 30-bit wrap counter that forms the top
// of the 64-bit timestamp. The block sustains one word per clock unless the
// decode stage is stalled: a word is registered on entry, decoded and applied
// to the time base in the next cycle, and its event is held in an output
// register. Back pressure on the output stalls the decode stage only when it
// holds a word that produces an event. Write the configuration registers only
// while no words are in flight.
module event_stream_timestamp_decoder_core
    import esd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: raw_word[31:0].
    input  logic [WORD_W-1:0]     s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: pixel_x[10:0], pixel_y[21:11], polarity[22],
    // trigger_channel[27:23], trigger_level[28], event_time[92:29], zero pad.
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: event_kind[0].
    output logic                  m_axis_tuser
);

    // Configuration registers.
    logic              r_trigger_enable;
    logic [THR_W-1:0]  r_loop_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_enable <= 1'b0;
            r_loop_threshold <= THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRIGGER_ENABLE: r_trigger_enable <= i_cfg_data[0];
                CFG_LOOP_THRESHOLD: r_loop_threshold <= i_cfg_data[THR_W-1:0];
                default: begin
                    r_trigger_enable <= r_trigger_enable;
                end
            endcase
        end
    end

    // Input register stage.
    logic              r_in_valid;
    logic [WORD_W-1:0] r_in_word;

    // Decode stage signals.
    t_base             base;
    logic              emit;
    logic              high_word;
    t_event            dec_event;
    logic              out_free;
    logic              fire;

    // Output register stage.
    logic              r_out_valid;
    t_event            r_out_event;

    assign out_free      = !r_out_valid || m_axis_tready;
    // A word that yields no event retires even while the output is stalled.
    assign fire          = r_in_valid && (!emit || out_free);
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_word <= s_axis_tdata;
        end
    end

    esd_decode u_decode (
        .i_word           (r_in_word),
        .i_base           (base),
        .i_trigger_enable (r_trigger_enable),
        .o_emit           (emit),
        .o_high_word      (high_word),
        .o_event          (dec_event)
    );

    esd_timebase u_timebase (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_update    (fire && high_word),
        .i_high      (r_in_word[HIGH_TIME_BITS-1:0]),
        .i_threshold (r_loop_threshold),
        .o_base      (base)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out_event <= dec_event;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_event.kind;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}},
                            r_out_event.ts,
                            r_out_event.level,
                            r_out_event.chan,
                            r_out_event.pol,
                            r_out_event.y,
                            r_out_event.x};

endmodule

FILE: dv/tb_event_stream_timestamp_decoder_core.sv
module tb_event_stream_timestamp_decoder_core
    import esd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Watchdog limit in clock cycles. It leaves a wide margin over what a slow
    // but correct run needs.
    localparam int CYCLE_LIMIT  = 200000;
    // Cycles to let pass once nothing is expected, so that a word that makes no
    // event has left the two-stage pipeline before the next register write.
    localparam int DRAIN_CYCLES = 8;
    // Length of the one long hold-off on the output side.
    localparam int LONG_HOLD    = 150;

    // Type codes that the decoder does not know; such words must be dropped.
    localparam logic [TYPE_W-1:0] TYPE_RESERVED_2 = 4'h2;
    localparam logic [TYPE_W-1:0] TYPE_RESERVED_F = 4'hF;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_TRIGGER_ENABLE;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // Fields from bit 0: raw_word[31:0].
    logic [WORD_W-1:0]     s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    // Fields from bit 0: pixel_x[10:0], pixel_y[21:11], polarity[22],
    // trigger_channel[27:23], trigger_level[28], event_time[92:29], zero pad.
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // Fields from bit 0: event_kind[0].
    logic                  m_axis_tuser;

    // Set by the stimulus to ask the output side for one long stall.
    bit                        hold_req = 1'b0;
    // Set for the last phase: no gaps on the input and no stalls on the output.
    bit                        no_idle  = 1'b0;
    // Time-high field of the simulated sensor clock in the random part.
    logic [HIGH_TIME_BITS-1:0] sensor_high = '0;
    int                        cycle_count = 0;

    // Keeps its own copy of the decoder state and registers, turns every accepted
    // input word into the event it must produce, if any, and compares the events
    // that come out against those in order.
    class event_scoreboard;
        bit                        trig_en;
        logic [THR_W-1:0]          margin_units;
        logic [TIME_W-1:0]         time_base;
        logic [WRAP_BITS-1:0]      wrap_count;
        bit                        base_seen;
        t_event                    pending_events[$];
        int                        errors;

        function new();
            trig_en      = 1'b0;
            margin_units = THR_RESET;
            time_base    = '0;
            wrap_count   = '0;
            base_seen    = 1'b0;
            errors       = 0;
        endfunction

        function void set_regs(bit te, logic [THR_W-1:0] thr);
            trig_en      = te;
            margin_units = thr;
        endfunction

        function bit idle();
            return pending_events.size() == 0;
        endfunction

        function void decode_word(logic [WORD_W-1:0] word);
            logic [TYPE_W-1:0] wtype;
            logic [TIME_W-1:0] next_base;
            logic [TIME_W-1:0] wrap_span;
            t_event            ev;
            wtype = word[31:28];
            ev    = '0;
            // Until the first time-high word there is no time base at all.
            if (!base_seen) begin
                if (wtype == TYPE_TIME_HIGH) begin
                    time_base = TIME_W'(word[27:0]) << LOW_TIME_BITS;
                    base_seen = 1'b1;
                end
                return;
            end
            if (wtype == TYPE_TIME_HIGH) begin
                next_base = {wrap_count, word[27:0], {LOW_TIME_BITS{1'b0}}};
                // A backward step of at least the full range less the margin is a
                // wrap of the sensor clock.
                wrap_span = (TIME_W'(1) << (HIGH_TIME_BITS + LOW_TIME_BITS))
                          - (TIME_W'(1) << LOW_TIME_BITS)
                          - (TIME_W'(margin_units) << LOW_TIME_BITS);
                if (time_base > next_base && time_base - next_base >= wrap_span) begin
                    next_base  = next_base + (TIME_W'(1) << (HIGH_TIME_BITS + LOW_TIME_BITS));
                    wrap_count = wrap_count + 1'b1;
                end
                time_base = next_base;
                return;
            end
            if (wtype == TYPE_CD_OFF || wtype == TYPE_CD_ON) begin
                ev.kind = KIND_CD;
                ev.x    = word[21:11];
                ev.y    = word[10:0];
                ev.pol  = wtype[0];
                ev.ts   = time_base + TIME_W'(word[27:22]);
                pending_events.push_back(ev);
            end else if (wtype == TYPE_EXT_TRIGGER && trig_en) begin
                ev.kind  = KIND_TRIGGER;
                ev.chan  = word[12:8];
                ev.level = word[0];
                ev.ts    = time_base + TIME_W'(word[27:22]);
                pending_events.push_back(ev);
            end
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void match_event(t_event got);
            t_event want;
            if (pending_events.size() == 0) begin
                errors++;
                $display("%0t: event with none expected: expected nothing, actual %0h",
                         $time, got);
                return;
            end
            want = pending_events.pop_front();
            check_field("event_kind", want.kind, got.kind);
            check_field("pixel_x", want.x, got.x);
            check_field("pixel_y", want.y, got.y);
            check_field("polarity", want.pol, got.pol);
            check_field("trigger_channel", want.chan, got.chan);
            check_field("trigger_level", want.level, got.level);
            check_field("event_time", want.ts, got.ts);
        endfunction
    endclass

    event_scoreboard sb;

    event_stream_timestamp_decoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: a run that hangs on a handshake ends here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** event_stream_timestamp_decoder_core: FAILED **");
            $finish;
        end
    end

    // Output side. The ready line stalls in short random bursts, and once, on
    // request, for a long stretch so that the pipeline fills and the input stalls.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                m_axis_tready <= 1'b1;
                hold_req = 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Every word taken on the output side is unpacked and checked in order.
    always @(posedge i_clk) begin : output_monitor
        t_event got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind  = m_axis_tuser;
            got.x     = m_axis_tdata[10:0];
            got.y     = m_axis_tdata[21:11];
            got.pol   = m_axis_tdata[22];
            got.chan  = m_axis_tdata[27:23];
            got.level = m_axis_tdata[28];
            got.ts    = m_axis_tdata[92:29];
            sb.match_event(got);
        end
    end

    // Offers one input word, sometimes after a short gap, and holds it until the
    // decoder takes it. The valid line is left high on return so that the next
    // word can follow back to back.
    task automatic send_word(input logic [WORD_W-1:0] word);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.decode_word(word);
    endtask

    // Stops the input and waits until every expected event has come out, then
    // waits for words that produce nothing to leave the pipeline.
    task automatic drain_decoder();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (!sb.idle()) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers, one after the other, while the decoder is idle.
    task automatic write_regs(input bit te, input logic [THR_W-1:0] thr);
        drain_decoder();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TRIGGER_ENABLE;
        i_cfg_data  <= CFG_DATA_W'(te);
        @(posedge i_clk);
        i_cfg_index <= CFG_LOOP_THRESHOLD;
        i_cfg_data  <= thr;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_regs(te, thr);
    endtask

    function automatic logic [WORD_W-1:0] cd_word(input logic pol, input logic [5:0] low,
                                                  input logic [10:0] x, input logic [10:0] y);
        return {(pol ? TYPE_CD_ON : TYPE_CD_OFF), low, x, y};
    endfunction

    // A trigger word; the unused bits are all set to fill.
    function automatic logic [WORD_W-1:0] trig_word(input logic [5:0] low,
                                                    input logic [CHAN_W-1:0] chan,
                                                    input logic level, input logic fill);
        return {TYPE_EXT_TRIGGER, low, {9{fill}}, chan, {7{fill}}, level};
    endfunction

    function automatic logic [WORD_W-1:0] high_word(input logic [HIGH_TIME_BITS-1:0] field);
        return {TYPE_TIME_HIGH, field};
    endfunction

    // Random traffic that looks like a sensor stream: mostly contrast events,
    // time-high words that walk forward and now and then wrap or jump back, trigger
    // words and some noise of any type. Every word sent counts toward the number
    // asked for.
    task automatic run_random(input int n_words);
        int                counted;
        int                sel;
        logic [31:0]       bits;
        logic [WORD_W-1:0] word;
        counted = 0;
        while (counted < n_words) begin
            bits = $urandom();
            sel  = $urandom_range(0, 99);
            if (sel < 50) begin
                word = {(bits[31] ? TYPE_CD_ON : TYPE_CD_OFF), bits[27:0]};
            end else if (sel < 65) begin
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    // Normal forward step; near the top it rolls over to a small value.
                    sensor_high = sensor_high + HIGH_TIME_BITS'($urandom_range(0, 120));
                end else if (sel < 75) begin
                    sensor_high = HIGH_MAX - HIGH_TIME_BITS'($urandom_range(0, 300));
                end else if (sel < 88) begin
                    sensor_high = HIGH_TIME_BITS'($urandom_range(0, 300));
                end else begin
                    sensor_high = bits[27:0];
                end
                word = high_word(sensor_high);
            end else if (sel < 85) begin
                word = {TYPE_EXT_TRIGGER, bits[27:0]};
            end else begin
                word = bits;
            end
            counted++;
            send_word(word);
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, first with the register values from reset. Nothing may
        // come out before the first time-high word.
        send_word(cd_word(1'b1, 6'h3F, 11'h7FF, 11'h7FF));
        send_word(trig_word(6'h3F, 5'h1F, 1'b1, 1'b1));
        send_word({TYPE_RESERVED_F, 28'h0000000});
        send_word(high_word(HIGH_MAX));
        send_word(cd_word(1'b0, 6'h3F, 11'h7FF, 11'h000));
        send_word(cd_word(1'b1, 6'h00, 11'h000, 11'h7FF));
        // Triggers are still disabled, and an unknown type is dropped.
        send_word(trig_word(6'h2A, 5'h15, 1'b1, 1'b0));
        send_word({TYPE_RESERVED_2, 28'hFFFFFFF});
        // From the top of the range back to zero: a wrap with the default margin.
        send_word(high_word('0));
        send_word(cd_word(1'b0, 6'h15, 11'h2AA, 11'h555));

        // Triggers on, zero margin: only a step of the full range is a wrap.
        write_regs(1'b1, 8'd0);
        send_word(trig_word(6'h3F, 5'h1F, 1'b1, 1'b0));
        send_word(trig_word(6'h00, 5'h00, 1'b0, 1'b1));
        send_word(high_word(HIGH_MAX));
        send_word(high_word(28'd1));
        send_word(high_word(HIGH_MAX));
        send_word(high_word('0));
        send_word(cd_word(1'b1, 6'h3F, 11'h000, 11'h000));

        // Largest margin: a step back that ends just inside and just outside it.
        write_regs(1'b1, 8'd255);
        send_word(high_word(HIGH_MAX));
        send_word(high_word(28'd255));
        send_word(cd_word(1'b0, 6'h01, 11'h001, 11'h400));
        send_word(high_word(HIGH_MAX));
        send_word(high_word(28'd256));
        send_word(trig_word(6'h21, 5'h0A, 1'b1, 1'b0));

        // Random part over several register settings. The first phase opens with
        // the long output stall while words keep coming.
        write_regs(1'b1, THR_RESET);
        hold_req = 1'b1;
        run_random(120);
        write_regs(1'b0, THR_W'($urandom_range(1, 254)));
        run_random(100);
        write_regs(1'b1, 8'd255);
        run_random(110);
        write_regs(1'b1, 8'd0);
        no_idle = 1'b1;
        run_random(120);

        drain_decoder();
        if (sb.errors == 0) begin
            $display("** event_stream_timestamp_decoder_core: PASSED **");
        end else begin
            $display("** event_stream_timestamp_decoder_core: FAILED **");
        end
        $finish;
    end

endmodule
